// File: sv/ies_pkg.sv
`default_nettype none
package ies_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_IDENT = 2'd2;

   localparam logic [7:0] EFF_BLINK   = 8'd0;
   localparam logic [7:0] EFF_BREATHE = 8'd1;
   localparam logic [7:0] EFF_OKAY    = 8'd2;
   localparam logic [7:0] EFF_CHANNEL = 8'd11;
   localparam logic [7:0] EFF_FINISH  = 8'd254;
   localparam logic [7:0] EFF_STOP    = 8'd255;

   localparam logic [7:0] LEVEL_MAX     = 8'd250;
   localparam logic [7:0] LEVEL_STEP    = 8'd50;
   localparam logic [7:0] LEVEL_OKAY    = 8'd254;
   localparam logic [7:0] LEVEL_CHAN    = 8'd254;
   localparam logic [7:0] OKAY_MARK_A   = 8'd10;
   localparam logic [7:0] OKAY_MARK_B   = 8'd5;
   localparam logic [7:0] CHAN_MARK     = 8'd74;
   localparam logic [7:0] TICKS_BLINK   = 8'd10;
   localparam logic [7:0] TICKS_BREATHE = 8'd200;
   localparam logic [7:0] TICKS_OKAY    = 8'd15;
   localparam logic [7:0] TICKS_CHAN    = 8'd80;
   localparam logic [7:0] BREATHE_REPS  = 8'd15;
   localparam logic [7:0] IDENT_PERIOD  = 8'd5;

   localparam logic [4:0] TIME_STOP    = 5'd1;
   localparam logic [4:0] TIME_BLINK   = 5'd2;
   localparam logic [4:0] TIME_OKAY    = 5'd3;
   localparam logic [4:0] TIME_CHAN    = 5'd9;
   localparam logic [4:0] TIME_BREATHE = 5'd17;

   localparam logic [7:0] OWN_EP_RESET = 8'd1;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  endpoint;
      logic [7:0]  effect_code;
      logic [15:0] identify_time;
      logic        light_on;
   } ies_req_type;

   typedef struct packed {
      logic       led_update;
      logic       led_on;
      logic [7:0] level_out;
      logic       time_write;
      logic [4:0] time_value;
   } ies_rsp_type;

   typedef struct packed {
      logic [7:0] current_effect;
      logic [7:0] tick_count;
      logic [7:0] effect_level;
      logic [7:0] blink_count;
      logic       rising;
      logic       finish_pending;
      logic       identify_active;
   } ies_state_type;

   localparam ies_state_type STATE_RESET = '{
      current_effect:  EFF_STOP,
      tick_count:      8'd0,
      effect_level:    8'd0,
      blink_count:     8'd0,
      rising:          1'b0,
      finish_pending:  1'b0,
      identify_active: 1'b0
   };

endpackage
`default_nettype wire

// File: sv/ies_if.sv
`default_nettype none
interface ies_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  endpoint;
   logic [7:0]  effect_code;
   logic [15:0] identify_time;
   logic        light_on;

   modport source (output valid, op, endpoint, effect_code, identify_time, light_on,
                   input ready);
   modport sink (input valid, op, endpoint, effect_code, identify_time, light_on,
                 output ready);
endinterface

interface ies_rsp_if;
   logic       valid;
   logic       ready;
   logic       led_update;
   logic       led_on;
   logic [7:0] level_out;
   logic       time_write;
   logic [4:0] time_value;

   modport source (output valid, led_update, led_on, level_out, time_write, time_value,
                   input ready);
   modport sink (input valid, led_update, led_on, level_out, time_write, time_value,
                 output ready);
endinterface

interface ies_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: sv/ies_step.sv
`default_nettype none
module ies_step (
   input  ies_pkg::ies_state_type state,
   input  ies_pkg::ies_req_type   req,
   input  logic [7:0]             own_endpoint,
   output ies_pkg::ies_state_type state_next,
   output ies_pkg::ies_rsp_type   rsp
);
   import ies_pkg::*;

   ies_state_type st;
   logic          upd;
   logic          led;
   logic          tw;
   logic [4:0]    tv;
   logic          running;
   logic [7:0]    tick_dec;
   logic [7:0]    blink_dec;

   assign running   = (state.current_effect != EFF_STOP);
   assign tick_dec  = state.tick_count - 8'd1;
   assign blink_dec = state.blink_count - 8'd1;

   always_comb begin
      st  = state;
      upd = 1'b0;
      led = 1'b0;
      tw  = 1'b0;
      tv  = 5'd0;
      unique case (req.op)
         OP_TICK: begin
            if (req.endpoint == own_endpoint) begin
               if (running) begin
                  if (state.tick_count != 8'd0) begin
                     st.tick_count = tick_dec;
                     upd = 1'b1;
                     led = 1'b1;
                     case (state.current_effect)
                        EFF_BLINK: begin
                        end
                        EFF_BREATHE: begin
                           if (state.rising) begin
                              if (state.effect_level >= LEVEL_MAX) begin
                                 st.effect_level = state.effect_level - LEVEL_STEP;
                                 st.rising       = 1'b0;
                              end else begin
                                 st.effect_level = state.effect_level + LEVEL_STEP;
                              end
                           end else if (state.effect_level == 8'd0) begin
                              st.blink_count = blink_dec;
                              if (blink_dec != 8'd0 && !state.finish_pending) begin
                                 st.effect_level = state.effect_level + LEVEL_STEP;
                                 st.rising       = 1'b1;
                              end else begin
                                 st.tick_count = 8'd0;
                              end
                           end else begin
                              st.effect_level = state.effect_level - LEVEL_STEP;
                           end
                        end
                        EFF_OKAY: begin
                           if (tick_dec == OKAY_MARK_A || tick_dec == OKAY_MARK_B) begin
                              st.effect_level = state.effect_level ^ LEVEL_OKAY;
                              if (state.finish_pending) st.tick_count = 8'd0;
                           end
                        end
                        EFF_CHANNEL: begin
                           if (tick_dec == CHAN_MARK) begin
                              st.effect_level = 8'd1;
                              if (state.finish_pending) st.tick_count = 8'd0;
                           end
                        end
                        default: begin
                           if (state.finish_pending) st.tick_count = 8'd0;
                        end
                     endcase
                  end else begin
                     // countdown done: effect ends, LED follows the light
                     st.current_effect = EFF_STOP;
                     st.rising         = 1'b0;
                     tw  = 1'b1;
                     tv  = 5'd0;
                     upd = 1'b1;
                     led = req.light_on;
                  end
               end else if (req.identify_time != 16'd0) begin
                  // default identify blink
                  st.blink_count = blink_dec;
                  if (blink_dec == 8'd0) begin
                     st.blink_count = IDENT_PERIOD;
                     upd = 1'b1;
                     if (state.effect_level != 8'd0) begin
                        st.effect_level = 8'd0;
                        led = 1'b0;
                     end else begin
                        st.effect_level = LEVEL_MAX;
                        led = 1'b1;
                     end
                  end
               end
            end
         end
         OP_START: begin
            unique case (req.effect_code)
               EFF_BLINK: begin
                  st.current_effect = EFF_BLINK;
                  st.effect_level   = req.light_on ? 8'd0 : LEVEL_MAX;
                  st.finish_pending = 1'b0;
                  st.tick_count     = TICKS_BLINK;
                  tw = 1'b1;
                  tv = TIME_BLINK;
               end
               EFF_BREATHE: begin
                  st.current_effect = EFF_BREATHE;
                  st.rising         = 1'b1;
                  st.finish_pending = 1'b0;
                  st.effect_level   = 8'd0;
                  st.blink_count    = BREATHE_REPS;
                  st.tick_count     = TICKS_BREATHE;
                  tw = 1'b1;
                  tv = TIME_BREATHE;
               end
               EFF_OKAY: begin
                  st.current_effect = EFF_OKAY;
                  st.finish_pending = 1'b0;
                  st.effect_level   = req.light_on ? 8'd0 : LEVEL_OKAY;
                  st.tick_count     = TICKS_OKAY;
                  tw = 1'b1;
                  tv = TIME_OKAY;
               end
               EFF_CHANNEL: begin
                  st.current_effect = EFF_CHANNEL;
                  st.effect_level   = LEVEL_CHAN;
                  st.finish_pending = 1'b0;
                  st.tick_count     = TICKS_CHAN;
                  tw = 1'b1;
                  tv = TIME_CHAN;
               end
               EFF_FINISH: begin
                  if (running) st.finish_pending = 1'b1;
               end
               EFF_STOP: begin
                  st.current_effect = EFF_STOP;
                  tw = 1'b1;
                  tv = TIME_STOP;
               end
               default: begin
               end
            endcase
         end
         OP_IDENT: begin
            if (!running) begin
               if (req.identify_time == 16'd0) begin
                  upd = 1'b1;
                  led = req.light_on;
                  st.identify_active = 1'b0;
               end else if (!state.identify_active) begin
                  st.identify_active = 1'b1;
                  st.effect_level    = LEVEL_MAX;
                  st.blink_count     = IDENT_PERIOD;
                  upd = 1'b1;
                  led = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign state_next     = st;
   assign rsp.led_update = upd;
   assign rsp.led_on     = upd & led;
   assign rsp.level_out  = st.effect_level;
   assign rsp.time_write = tw;
   assign rsp.time_value = tw ? tv : 5'd0;

endmodule
`default_nettype wire

// File: sv/identify_effect_sequencer.sv
`default_nettype none
// Identify-effect LED sequencer. Each request beat is a tick, a start-effect
// command or an identify-time change; each one yields exactly one response
// beat carrying an optional LED drive, the effect level and an optional
// identify-time write. Throughput is one beat per clock while rsp is ready;
// each request passes the input register, the combinational state update
// and the response register. Back-pressure on rsp stalls the input register.
// own_endpoint (reset 1) selects which ticks are acted on; write it over csr
// only while no beat is in flight.
module identify_effect_sequencer (
   input  logic       clock,
   input  logic       reset,
   ies_req_if.sink    req_ch,
   ies_rsp_if.source  rsp_ch,
   ies_csr_if.sink    csr_ch
);
   import ies_pkg::*;

   logic          req_valid_ff;
   ies_req_type   req_data_ff;
   ies_req_type   req_data_in;
   logic          rsp_valid_ff;
   ies_rsp_type   rsp_data_ff;
   ies_rsp_type   rsp_data_in;
   ies_state_type state_ff;
   ies_state_type state_in;
   logic [7:0]    own_endpoint_ff;
   logic          advance;
   logic          req_take;

   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready   = !req_valid_ff || advance;
   assign req_take       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready   = 1'b1;

   assign req_data_in.op            = req_ch.op;
   assign req_data_in.endpoint      = req_ch.endpoint;
   assign req_data_in.effect_code   = req_ch.effect_code;
   assign req_data_in.identify_time = req_ch.identify_time;
   assign req_data_in.light_on      = req_ch.light_on;

   ies_step u_step (
      .state        (state_ff),
      .req          (req_data_ff),
      .own_endpoint (own_endpoint_ff),
      .state_next   (state_in),
      .rsp          (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         state_ff        <= STATE_RESET;
         own_endpoint_ff <= OWN_EP_RESET;
      end else begin
         if (req_take) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_ch.valid) begin
            own_endpoint_ff <= csr_ch.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff <= req_data_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.led_update = rsp_data_ff.led_update;
   assign rsp_ch.led_on     = rsp_data_ff.led_on;
   assign rsp_ch.level_out  = rsp_data_ff.level_out;
   assign rsp_ch.time_write = rsp_data_ff.time_write;
   assign rsp_ch.time_value = rsp_data_ff.time_value;

endmodule
`default_nettype wire

// File: test/identify_effect_sequencer_tb.sv
module identify_effect_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ies_pkg::*;

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam logic [7:0] EFF_UNDEFINED = 8'h7F;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 6;
   localparam int IDLE_PCT     = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ies_req_if req_ch ();
   ies_rsp_if rsp_ch ();
   ies_csr_if csr_ch ();

   identify_effect_sequencer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow of the sequencer state and its endpoint register
   ies_state_type seq_state = STATE_RESET;
   logic [7:0]    own_ep    = OWN_EP_RESET;
   ies_rsp_type   led_result_q[$];

   int  beats_sent     = 0;
   int  beats_checked  = 0;
   int  mismatch_count = 0;
   int  csr_writes     = 0;
   bit  req_idle_on    = 1'b1;
   bit  rsp_stall_on   = 1'b1;

   always #4 clock = ~clock;

   function automatic ies_rsp_type next_led_result(input ies_req_type r);
      ies_state_type s;
      ies_rsp_type   o;
      logic          upd, led, tw;
      logic [4:0]    tv;
      s   = seq_state;
      upd = 1'b0;
      led = 1'b0;
      tw  = 1'b0;
      tv  = 5'd0;
      case (r.op)
         OP_TICK: if (r.endpoint == own_ep) begin
            if (s.current_effect != EFF_STOP) begin
               if (s.tick_count != 8'd0) begin
                  s.tick_count = s.tick_count - 8'd1;
                  upd = 1'b1;
                  led = 1'b1;
                  case (s.current_effect)
                     EFF_BLINK: ;
                     EFF_BREATHE: begin
                        if (s.rising) begin
                           if (s.effect_level >= LEVEL_MAX) begin
                              s.effect_level = s.effect_level - LEVEL_STEP;
                              s.rising = 1'b0;
                           end else begin
                              s.effect_level = s.effect_level + LEVEL_STEP;
                           end
                        end else if (s.effect_level == 8'd0) begin
                           // bottom of a breath: one repeat used up
                           s.blink_count = s.blink_count - 8'd1;
                           if (s.blink_count != 8'd0 && !s.finish_pending) begin
                              s.effect_level = s.effect_level + LEVEL_STEP;
                              s.rising = 1'b1;
                           end else begin
                              s.tick_count = 8'd0;
                           end
                        end else begin
                           s.effect_level = s.effect_level - LEVEL_STEP;
                        end
                     end
                     EFF_OKAY: begin
                        if (s.tick_count == OKAY_MARK_A || s.tick_count == OKAY_MARK_B) begin
                           s.effect_level = s.effect_level ^ LEVEL_OKAY;
                           if (s.finish_pending) s.tick_count = 8'd0;
                        end
                     end
                     EFF_CHANNEL: begin
                        if (s.tick_count == CHAN_MARK) begin
                           s.effect_level = 8'd1;
                           if (s.finish_pending) s.tick_count = 8'd0;
                        end
                     end
                     default: begin
                        if (s.finish_pending) s.tick_count = 8'd0;
                     end
                  endcase
               end else begin
                  // effect ran out: clear identify time, LED follows the light
                  s.current_effect = EFF_STOP;
                  s.rising = 1'b0;
                  tw  = 1'b1;
                  tv  = 5'd0;
                  upd = 1'b1;
                  led = r.light_on;
               end
            end else if (r.identify_time != 16'd0) begin
               s.blink_count = s.blink_count - 8'd1;
               if (s.blink_count == 8'd0) begin
                  s.blink_count = IDENT_PERIOD;
                  upd = 1'b1;
                  if (s.effect_level != 8'd0) begin
                     s.effect_level = 8'd0;
                     led = 1'b0;
                  end else begin
                     s.effect_level = LEVEL_MAX;
                     led = 1'b1;
                  end
               end
            end
         end
         OP_START: begin
            case (r.effect_code)
               EFF_BLINK: begin
                  s.current_effect = EFF_BLINK;
                  s.effect_level   = r.light_on ? 8'd0 : LEVEL_MAX;
                  s.finish_pending = 1'b0;
                  s.tick_count     = TICKS_BLINK;
                  tw = 1'b1;
                  tv = TIME_BLINK;
               end
               EFF_BREATHE: begin
                  s.current_effect = EFF_BREATHE;
                  s.rising         = 1'b1;
                  s.finish_pending = 1'b0;
                  s.effect_level   = 8'd0;
                  s.blink_count    = BREATHE_REPS;
                  s.tick_count     = TICKS_BREATHE;
                  tw = 1'b1;
                  tv = TIME_BREATHE;
               end
               EFF_OKAY: begin
                  s.current_effect = EFF_OKAY;
                  s.finish_pending = 1'b0;
                  s.effect_level   = r.light_on ? 8'd0 : LEVEL_OKAY;
                  s.tick_count     = TICKS_OKAY;
                  tw = 1'b1;
                  tv = TIME_OKAY;
               end
               EFF_CHANNEL: begin
                  s.current_effect = EFF_CHANNEL;
                  s.effect_level   = LEVEL_CHAN;
                  s.finish_pending = 1'b0;
                  s.tick_count     = TICKS_CHAN;
                  tw = 1'b1;
                  tv = TIME_CHAN;
               end
               EFF_FINISH: begin
                  if (s.current_effect != EFF_STOP) s.finish_pending = 1'b1;
               end
               EFF_STOP: begin
                  s.current_effect = EFF_STOP;
                  tw = 1'b1;
                  tv = TIME_STOP;
               end
               default: ;
            endcase
         end
         OP_IDENT: if (s.current_effect == EFF_STOP) begin
            if (r.identify_time == 16'd0) begin
               upd = 1'b1;
               led = r.light_on;
               s.identify_active = 1'b0;
            end else if (!s.identify_active) begin
               s.identify_active = 1'b1;
               s.effect_level    = LEVEL_MAX;
               s.blink_count     = IDENT_PERIOD;
               upd = 1'b1;
               led = 1'b0;
            end
         end
         default: ;
      endcase
      o.led_update = upd;
      o.led_on     = upd & led;
      o.level_out  = s.effect_level;
      o.time_write = tw;
      o.time_value = tw ? tv : 5'd0;
      seq_state = s;
      return o;
   endfunction

   function automatic logic [7:0] rand8();
      return 8'($urandom);
   endfunction

   function automatic ies_req_type make_req(input logic [1:0] op, input logic [7:0] ep,
                                            input logic [7:0] code, input logic [15:0] itime,
                                            input logic lon);
      return '{op, ep, code, itime, lon};
   endfunction

   function automatic logic [7:0] pick_effect();
      case ($urandom_range(0, 3))
         0:       return EFF_BLINK;
         1:       return EFF_BREATHE;
         2:       return EFF_OKAY;
         default: return EFF_CHANNEL;
      endcase
   endfunction

   // starts and ends at a falling edge; valid stays high between back-to-back beats
   task automatic send_req(input ies_req_type r);
      while (req_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid         = 1'b1;
      req_ch.op            = r.op;
      req_ch.endpoint      = r.endpoint;
      req_ch.effect_code   = r.effect_code;
      req_ch.identify_time = r.identify_time;
      req_ch.light_on      = r.light_on;
      do @(posedge clock); while (!req_ch.ready);
      led_result_q.push_back(next_led_result(r));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid = 1'b0;
      while (led_result_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_own_endpoint(input logic [7:0] value);
      drain_results();
      csr_ch.valid = 1'b1;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      own_ep = value;
      csr_writes++;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic send_own_tick(input logic [15:0] itime);
      send_req(make_req(OP_TICK, own_ep, rand8(), itime, 1'($urandom)));
   endtask

   task automatic send_noise();
      logic [7:0] ep;
      ep = ($urandom_range(0, 1) != 0) ? own_ep : rand8();
      send_req(make_req(2'($urandom), ep, rand8(), 16'($urandom), 1'($urandom)));
   endtask

   // one effect from start until it stops, with finish/stop/foreign beats sprinkled in
   task automatic run_effect(input logic [7:0] code);
      int n;
      int roll;
      n = 0;
      send_req(make_req(OP_START, rand8(), code, 16'($urandom), 1'($urandom)));
      while (seq_state.current_effect != EFF_STOP && n < 400) begin
         roll = $urandom_range(0, 99);
         if (roll < 86)
            send_own_tick(16'($urandom));
         else if (roll < 89)
            send_req(make_req(OP_START, rand8(), EFF_FINISH, 16'($urandom), 1'($urandom)));
         else if (roll < 90)
            send_req(make_req(OP_START, rand8(), EFF_STOP, 16'($urandom), 1'($urandom)));
         else if (roll < 94)
            send_req(make_req(OP_TICK, own_ep ^ 8'($urandom_range(1, 255)), rand8(),
                              16'($urandom), 1'($urandom)));
         else if (roll < 97)
            send_req(make_req(OP_IDENT, rand8(), rand8(), 16'($urandom), 1'($urandom)));
         else
            send_req(make_req(OP_START, rand8(), pick_effect(), 16'($urandom), 1'($urandom)));
         n++;
      end
      // one more tick once the effect has stopped
      send_own_tick(16'($urandom));
   endtask

   task automatic run_identify_burst();
      logic [15:0] itime;
      int          roll;
      itime = 16'($urandom_range(1, 65535));
      send_req(make_req(OP_IDENT, rand8(), rand8(), itime, 1'($urandom)));
      repeat ($urandom_range(6, 40)) begin
         roll = $urandom_range(0, 99);
         if (roll < 85)
            send_own_tick(itime);
         else if (roll < 92)
            send_own_tick(16'd0);
         else if (roll < 96)
            send_req(make_req(OP_TICK, own_ep ^ 8'($urandom_range(1, 255)), rand8(),
                              itime, 1'($urandom)));
         else
            send_req(make_req(OP_IDENT, rand8(), rand8(), 16'($urandom_range(1, 65535)),
                              1'($urandom)));
      end
      send_req(make_req(OP_IDENT, rand8(), rand8(), 16'd0, 1'($urandom)));
   endtask

   task automatic test_directed_corners();
      send_req(make_req(OP_TICK, own_ep, EFF_BLINK, 16'h0000, 1'b1));
      // idle blink counter wraps below zero
      send_req(make_req(OP_TICK, own_ep, EFF_STOP, 16'hFFFF, 1'b0));
      send_req(make_req(OP_IDENT, 8'hFF, 8'h00, 16'h0000, 1'b1));
      send_req(make_req(OP_IDENT, 8'h00, 8'hFF, 16'h8001, 1'b0));
      send_req(make_req(OP_IDENT, 8'h00, 8'h00, 16'h0001, 1'b1));
      send_req(make_req(OP_TICK, 8'hFE, EFF_BLINK, 16'hFFFF, 1'b1));
      send_req(make_req(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 1'b1));
      send_req(make_req(OP_START, own_ep, EFF_UNDEFINED, 16'h0000, 1'b0));
      send_req(make_req(OP_START, own_ep, EFF_FINISH, 16'h0000, 1'b0));
      send_req(make_req(OP_START, own_ep, EFF_BLINK, 16'h0000, 1'b0));
      send_req(make_req(OP_IDENT, own_ep, EFF_BLINK, 16'h0000, 1'b1));
      send_own_tick(16'h0000);
      send_req(make_req(OP_START, own_ep, EFF_FINISH, 16'h0000, 1'b1));
      send_own_tick(16'hFFFF);
      send_req(make_req(OP_START, own_ep, EFF_STOP, 16'h0000, 1'b1));
      send_own_tick(16'h0000);
      send_req(make_req(OP_START, own_ep, EFF_BREATHE, 16'h0000, 1'b1));
      send_own_tick(16'h0000);
      send_own_tick(16'h0000);
      send_req(make_req(OP_START, own_ep, EFF_OKAY, 16'h0000, 1'b0));
      send_own_tick(16'h0000);
      send_req(make_req(OP_START, own_ep, EFF_CHANNEL, 16'h0000, 1'b1));
      send_req(make_req(OP_START, own_ep, EFF_STOP, 16'h0000, 1'b0));
      send_req(make_req(OP_IDENT, own_ep, EFF_STOP, 16'h0000, 1'b0));
   endtask

   task automatic test_identify_blink();
      int start;
      write_own_endpoint(OWN_EP_RESET);
      start = beats_sent;
      while (beats_sent - start < 400) run_identify_burst();
   endtask

   task automatic test_effect_runs();
      int start;
      write_own_endpoint(rand8());
      start = beats_sent;
      // back-to-back stretch with neither side idling
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b0;
      while (beats_sent - start < 900) begin
         if (beats_sent - start >= 300) begin
            req_idle_on  = 1'b1;
            rsp_stall_on = 1'b1;
         end
         run_effect(pick_effect());
      end
   endtask

   task automatic test_endpoint_register();
      logic [7:0] settings[3];
      int         start;
      int         roll;
      settings = '{8'h00, 8'hFF, rand8()};
      foreach (settings[k]) begin
         write_own_endpoint(settings[k]);
         start = beats_sent;
         while (beats_sent - start < 130) begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
               run_effect(pick_effect());
            else if (roll < 80)
               run_identify_burst();
            else
               repeat ($urandom_range(1, 5)) send_noise();
         end
      end
   endtask

   task automatic test_noise();
      write_own_endpoint(OWN_EP_RESET);
      repeat (150) send_noise();
   endtask

   always @(negedge clock) rsp_ch.ready = !(rsp_stall_on && $urandom_range(0, 99) < IDLE_PCT);

   always @(posedge clock) begin
      ies_rsp_type got;
      ies_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.led_update, rsp_ch.led_on, rsp_ch.level_out,
                 rsp_ch.time_write, rsp_ch.time_value};
         beats_checked++;
         if (led_result_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("rsp beat with nothing expected: upd=%0b led=%0b lvl=%0d tw=%0b tv=%0d",
                        got.led_update, got.led_on, got.level_out, got.time_write,
                        got.time_value);
         end else begin
            want = led_result_q.pop_front();
            if (got.led_update !== want.led_update || got.led_on !== want.led_on ||
                got.level_out !== want.level_out || got.time_write !== want.time_write ||
                got.time_value !== want.time_value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("rsp beat %0d: want upd=%0b led=%0b lvl=%0d tw=%0b tv=%0d,",
                           beats_checked, want.led_update, want.led_on, want.level_out,
                           want.time_write, want.time_value,
                           " got upd=%0b led=%0b lvl=%0d tw=%0b tv=%0d",
                           got.led_update, got.led_on, got.level_out, got.time_write,
                           got.time_value);
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.op            = OP_TICK;
      req_ch.endpoint      = 8'd0;
      req_ch.effect_code   = EFF_BLINK;
      req_ch.identify_time = 16'd0;
      req_ch.light_on      = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.data          = 8'd0;
      rsp_ch.ready         = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_corners();
      test_identify_blink();
      test_effect_runs();
      test_endpoint_register();
      test_noise();
      drain_results();

      $display("run: %0d req beats, %0d rsp beats checked, %0d mismatches",
               beats_sent, beats_checked, mismatch_count);
      $display("run: all effects with finish/stop, identify blink, %0d own_endpoint writes",
               csr_writes);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
